FILE: rtl/core/wtrp_pkg.sv
// wtrp_pkg: shared types, command codes and register indexes for the
// windowed token repetition penalty block
// no dependencies
`default_nettype none

package wtrp_pkg;

  // size defaults for the top level parameters
  localparam int unsigned MaxWindowDef = 8192;
  localparam int unsigned MaxVocabDef  = 32768;

  // fixed field widths
  localparam int unsigned CntW     = 14;
  localparam int unsigned TokW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // command codes
  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_PENALIZE = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_VOCAB_SIZE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LEN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_FACT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_INV   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FREQ_WEIGHT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PRES_WEIGHT  = 3'd5;

  // repeat factor of 1.0 in unsigned Q3.12
  localparam logic [14:0] REPEAT_ONE = 15'd4096;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        token_id;
    logic signed [31:0] logit_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] adjusted_logit;
    logic [CntW-1:0]    occurrence_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        vocab_size;
    logic [13:0]        window_length;
    logic [14:0]        repeat_factor;
    logic [12:0]        repeat_inverse;
    logic signed [15:0] frequency_weight;
    logic signed [15:0] presence_weight;
  } cfg_t;

  // operation of the shared multiply unit
  typedef enum logic [1:0] {
    MOP_NONE = 2'd0,
    MOP_REP  = 2'd1,
    MOP_FREQ = 2'd2
  } mop_e;

endpackage

`default_nettype wire

FILE: rtl/core/wtrp_math.sv
// wtrp_math: shared signed multiplier with rounding, presence offset and
// final saturating subtract for the penalty path
// depends on wtrp_pkg
`default_nettype none

module wtrp_math (
  input  wire                  clk_i,
  input  wire wtrp_pkg::mop_e  op_i,
  input  wire wtrp_pkg::cfg_t  cfg_i,
  input  wire logic signed [31:0] logit_i,
  input  wire logic [wtrp_pkg::CntW-1:0] count_i,
  output logic signed [31:0]   result_o
);

  logic signed [32:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [48:0] mul_p;
  logic signed [48:0] prod_q, prod_d;
  logic signed [37:0] rep_q, rep_d;
  logic signed [48:0] rnd;
  logic signed [36:0] rep_sel;
  logic signed [39:0] sum;
  logic               logit_pos;

  assign logit_pos = !logit_i[31] && (logit_i != 32'sd0);

  // operand select for the one multiplier
  always_comb begin
    mul_a = {logit_i[31], logit_i};
    mul_b = logit_pos ? $signed({3'b000, cfg_i.repeat_inverse})
                      : $signed({1'b0, cfg_i.repeat_factor});
    if (op_i == wtrp_pkg::MOP_FREQ) begin
      mul_a = {{17{cfg_i.frequency_weight[15]}}, cfg_i.frequency_weight};
      mul_b = $signed({2'b00, count_i});
    end
  end

  assign mul_p = mul_a * mul_b;

  // round to nearest, ties up: floor((p + 2048) / 4096)
  assign rnd = prod_q + 49'sd2048;

  always_comb begin
    if (cfg_i.repeat_factor == wtrp_pkg::REPEAT_ONE) begin
      rep_sel = {{5{logit_i[31]}}, logit_i};
    end else begin
      rep_sel = $signed(rnd[48:12]);
    end
  end

  always_comb begin
    prod_d = prod_q;
    rep_d  = rep_q;
    case (op_i)
      wtrp_pkg::MOP_REP: begin
        prod_d = mul_p;
      end
      wtrp_pkg::MOP_FREQ: begin
        rep_d  = {rep_sel[36], rep_sel}
               - {{18{cfg_i.presence_weight[15]}}, cfg_i.presence_weight, 4'b0000};
        prod_d = mul_p;
      end
      default: begin
        prod_d = prod_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rep_q  <= rep_d;
  end

  // frequency product fits well inside 36 bits
  assign sum = {{2{rep_q[37]}}, rep_q} - $signed({prod_q[35:0], 4'b0000});

  always_comb begin
    if (sum[39:31] == 9'h000 || sum[39:31] == 9'h1ff) begin
      result_o = sum[31:0];
    end else if (sum[39]) begin
      result_o = 32'sh8000_0000;
    end else begin
      result_o = 32'sh7fff_ffff;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/windowed_token_repetition_penalty.sv
// windowed_token_repetition_penalty: top level with the token ring, the
// count table, the sequencer and the configuration registers
// depends on wtrp_pkg and wtrp_math
`default_nettype none

//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  command   | start, busy, in_i (cmd, token, logit)   | taken when start & !busy
//  result    | res_strobe_o, res_o (logit, count)      | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i        | write on cfg_we_i, no wait
//
//  push: check, drop tokens from the window (one once full), then write the ring
//  penalize: zero count ends after the check; else the multiplier is used twice
//  clear: sweeps the count table, one entry zeroed per cycle
//  after reset the same sweep runs with busy high
//  results are strobed for one cycle and cannot be held off

module windowed_token_repetition_penalty #(
  parameter int unsigned MAX_WINDOW = wtrp_pkg::MaxWindowDef,
  parameter int unsigned MAX_VOCAB  = wtrp_pkg::MaxVocabDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire wtrp_pkg::in_word_t      in_i,
  output logic                         res_strobe_o,
  output wtrp_pkg::out_word_t          res_o,
  input  wire                          cfg_we_i,
  input  wire [wtrp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [wtrp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned PtrW  = $clog2(MAX_WINDOW);
  localparam int unsigned FillW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DiffW = FillW + 1;
  localparam int unsigned VidxW = $clog2(MAX_VOCAB);
  localparam int unsigned CntW  = wtrp_pkg::CntW;

  // one-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLEAR    = 9'b000000010,
    S_PUSH_CHK = 9'b000000100,
    S_DROP_CNT = 9'b000001000,
    S_DROP_WR  = 9'b000010000,
    S_PUSH_WR  = 9'b000100000,
    S_PEN_CNT  = 9'b001000000,
    S_PEN_FREQ = 9'b010000000,
    S_PEN_SUM  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  wtrp_pkg::cfg_t cfg_q;

  logic [PtrW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [VidxW-1:0] sweep_q, sweep_d;
  logic             strobe_q, strobe_d;

  // payload registers
  logic [15:0]        tok_q;
  logic signed [31:0] logit_q;
  logic [CntW-1:0]    n_q;
  wtrp_pkg::out_word_t res_q;

  // memories
  logic [15:0]     ring_mem [MAX_WINDOW];
  logic [CntW-1:0] cnt_mem  [MAX_VOCAB];
  logic [15:0]     ring_rdata_q;
  logic [CntW-1:0] cnt_rdata_q;

  logic             ring_re, ring_we;
  logic [PtrW-1:0]  ring_raddr;
  logic             cnt_we;
  logic [VidxW-1:0] cnt_raddr, cnt_waddr;
  logic [CntW-1:0]  cnt_wdata;

  logic             accept;
  logic [FillW-1:0] win_len;
  logic [DiffW-1:0] old_diff;
  logic [PtrW-1:0]  old_idx;
  logic             need_drop;
  logic             tok_in_vocab;
  logic             old_in_vocab;
  logic             pen_in_range;
  logic [CntW-1:0]  pen_count;

  wtrp_pkg::mop_e     mop;
  logic signed [31:0] math_result;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // active window: zero or oversized means the full ring
  always_comb begin
    if (cfg_q.window_length == 14'd0 || 32'(cfg_q.window_length) > MAX_WINDOW) begin
      win_len = FillW'(MAX_WINDOW);
    end else begin
      win_len = FillW'(cfg_q.window_length);
    end
  end

  assign need_drop = (fill_q >= win_len) && (fill_q != '0);

  // slot of the oldest token: head - fill, wrapped into the ring
  always_comb begin
    old_diff = DiffW'(head_q) - DiffW'(fill_q);
    if (old_diff[DiffW-1]) begin
      old_diff = old_diff + DiffW'(MAX_WINDOW);
    end
    old_idx = old_diff[PtrW-1:0];
  end

  assign tok_in_vocab = 32'(tok_q) < MAX_VOCAB;
  assign old_in_vocab = 32'(ring_rdata_q) < MAX_VOCAB;
  assign pen_in_range = tok_in_vocab && (tok_q < cfg_q.vocab_size);
  assign pen_count    = pen_in_range ? cnt_rdata_q : '0;

  // count table read address: the incoming token while idle so the
  // penalize path has its count in the cycle after accept
  always_comb begin
    cnt_raddr = tok_q[VidxW-1:0];
    case (state_q)
      S_IDLE:     cnt_raddr = in_i.token_id[VidxW-1:0];
      S_DROP_CNT: cnt_raddr = ring_rdata_q[VidxW-1:0];
      default:    cnt_raddr = tok_q[VidxW-1:0];
    endcase
  end

  assign ring_raddr = old_idx;

  // sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    fill_d   = fill_q;
    sweep_d  = sweep_q;
    strobe_d = 1'b0;
    ring_re  = 1'b0;
    ring_we  = 1'b0;
    cnt_we   = 1'b0;
    cnt_waddr = tok_q[VidxW-1:0];
    cnt_wdata = '0;
    mop      = wtrp_pkg::MOP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.cmd)
            wtrp_pkg::CMD_PUSH:     state_d = S_PUSH_CHK;
            wtrp_pkg::CMD_PENALIZE: state_d = S_PEN_CNT;
            wtrp_pkg::CMD_CLEAR: begin
              head_d  = '0;
              fill_d  = '0;
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_q;
        cnt_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (32'(sweep_q) == MAX_VOCAB - 1) begin
          state_d = S_IDLE;
        end
      end
      S_PUSH_CHK: begin
        // shrink the window until the new token fits
        if (need_drop) begin
          ring_re = 1'b1;
          state_d = S_DROP_CNT;
        end else begin
          ring_we = 1'b1;
          state_d = S_PUSH_WR;
        end
      end
      S_DROP_CNT: begin
        state_d = S_DROP_WR;
      end
      S_DROP_WR: begin
        cnt_waddr = ring_rdata_q[VidxW-1:0];
        cnt_wdata = cnt_rdata_q - 1'b1;
        cnt_we    = old_in_vocab && (cnt_rdata_q != '0);
        fill_d    = fill_q - 1'b1;
        state_d   = S_PUSH_CHK;
      end
      S_PUSH_WR: begin
        cnt_waddr = tok_q[VidxW-1:0];
        cnt_wdata = cnt_rdata_q + 1'b1;
        cnt_we    = tok_in_vocab && (cnt_rdata_q != '1);
        fill_d    = fill_q + 1'b1;
        if (32'(head_q) == MAX_WINDOW - 1) begin
          head_d = '0;
        end else begin
          head_d = head_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      S_PEN_CNT: begin
        // repetition product runs while the count is checked
        mop = wtrp_pkg::MOP_REP;
        if (pen_count == '0) begin
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_PEN_FREQ;
        end
      end
      S_PEN_FREQ: begin
        mop     = wtrp_pkg::MOP_FREQ;
        state_d = S_PEN_SUM;
      end
      S_PEN_SUM: begin
        strobe_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      head_q   <= '0;
      fill_q   <= '0;
      sweep_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      sweep_q  <= sweep_d;
      strobe_q <= strobe_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vocab_size       <= 16'd32768;
      cfg_q.window_length    <= 14'd0;
      cfg_q.repeat_factor    <= 15'd4096;
      cfg_q.repeat_inverse   <= 13'd4096;
      cfg_q.frequency_weight <= 16'sd0;
      cfg_q.presence_weight  <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtrp_pkg::REG_VOCAB_SIZE:  cfg_q.vocab_size       <= cfg_wdata_i;
        wtrp_pkg::REG_WINDOW_LEN:  cfg_q.window_length    <= cfg_wdata_i[13:0];
        wtrp_pkg::REG_REPEAT_FACT: cfg_q.repeat_factor    <= cfg_wdata_i[14:0];
        wtrp_pkg::REG_REPEAT_INV:  cfg_q.repeat_inverse   <= cfg_wdata_i[12:0];
        wtrp_pkg::REG_FREQ_WEIGHT: cfg_q.frequency_weight <= $signed(cfg_wdata_i);
        wtrp_pkg::REG_PRES_WEIGHT: cfg_q.presence_weight  <= $signed(cfg_wdata_i);
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // command payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q   <= in_i.token_id;
      logit_q <= in_i.logit_value;
    end
    if (state_q == S_PEN_CNT) begin
      n_q                    <= pen_count;
      res_q.adjusted_logit   <= logit_q;
      res_q.occurrence_count <= pen_count;
    end
    if (state_q == S_PEN_SUM) begin
      res_q.adjusted_logit   <= math_result;
      res_q.occurrence_count <= n_q;
    end
  end

  // token ring, read data registered
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= tok_q;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[ring_raddr];
    end
  end

  // count table, read data registered
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  wtrp_math u_math (
    .clk_i    (clk_i),
    .op_i     (mop),
    .cfg_i    (cfg_q),
    .logit_i  (logit_q),
    .count_i  (n_q),
    .result_o (math_result)
  );

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire
